// ===== rtl/matrix3x3_inverse_unit_assert.svh =====
// ---------------------------------------------------------------------------
// matrix3x3_inverse_unit assertion macros
// Wrappers for concurrent checks; defined empty when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3X3_INVERSE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define MI3_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("mi3 assertion failed");
`define MI3_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("mi3 assertion failed");
`else
`define MI3_ASSERT(lbl, clk, rstn, prop)
`define MI3_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/mi3_pkg.sv =====
// ---------------------------------------------------------------------------
// mi3_pkg
// Shared widths, status codes and types of the 3x3 inverse unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mi3_pkg;

	localparam int unsigned EW   = 32;          // matrix entry width
	localparam int unsigned CW   = 64;          // cofactor width (Q32.32)
	localparam int unsigned DW   = 98;          // determinant width (Q50.48)
	localparam int unsigned MW   = DW - 1;      // determinant magnitude width
	localparam int unsigned QW   = 32;          // quotient bits
	localparam int unsigned NENT = 9;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SAT  = 2'd1;
	localparam logic [1:0] STAT_SING = 2'd2;

	localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

	typedef logic signed [EW-1:0] entry_t;
	typedef logic signed [CW-1:0] cof_t;

	typedef struct packed {
		logic [MW-1:0] dmag;
		logic          dneg;
		logic          zero;
	} det_info_t;

	typedef struct packed {
		logic [EW-1:0] res;
		logic          sat;
		logic          zero;
	} lane_res_t;

endpackage

// ===== rtl/matrix3x3_inverse_unit.sv =====
// ---------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Q16.16 3x3 inverse by adjugate: cofactors, determinant, nine divide lanes,
// status merge.
//
//  channel | signals                              | beat
//  in      | in_valid/in_ready, in_r1c1..in_r3c3  | one matrix
//  out     | out_valid/out_ready, out_r*, status  | one inverse
//
// One matrix per cycle unless the output stalls; stages: 2 cofactor,
// 3 determinant, 34 divide-lane, 1 output stage. The divide lanes set the
// depth: one quotient bit per stage over 32 stages.
// The whole pipeline holds while a result waits at the output.
// Reset clears only the stage valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "matrix3x3_inverse_unit_assert.svh"

module matrix3x3_inverse_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] in_r1c1,
	input  logic signed [31:0] in_r1c2,
	input  logic signed [31:0] in_r1c3,
	input  logic signed [31:0] in_r2c1,
	input  logic signed [31:0] in_r2c2,
	input  logic signed [31:0] in_r2c3,
	input  logic signed [31:0] in_r3c1,
	input  logic signed [31:0] in_r3c2,
	input  logic signed [31:0] in_r3c3,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_r1c1,
	output logic signed [31:0] out_r1c2,
	output logic signed [31:0] out_r1c3,
	output logic signed [31:0] out_r2c1,
	output logic signed [31:0] out_r2c2,
	output logic signed [31:0] out_r2c3,
	output logic signed [31:0] out_r3c1,
	output logic signed [31:0] out_r3c2,
	output logic signed [31:0] out_r3c3,
	output logic [1:0]         inv_status
);

	localparam int unsigned NST = 40;

	logic                 en;
	logic [NST-1:0]       vld_q;
	mi3_pkg::entry_t      mat [mi3_pkg::NENT];
	mi3_pkg::cof_t        cof_s2 [mi3_pkg::NENT];
	mi3_pkg::cof_t        cof_s3 [mi3_pkg::NENT];
	mi3_pkg::cof_t        cof_s4 [mi3_pkg::NENT];
	mi3_pkg::cof_t        cof_s5 [mi3_pkg::NENT];
	mi3_pkg::entry_t      row_s2 [3];
	mi3_pkg::det_info_t   info_s5;
	mi3_pkg::lane_res_t   lane_res [mi3_pkg::NENT];
	logic [31:0]          out_q [mi3_pkg::NENT];
	logic [1:0]           stat_q;
	logic                 any_sat;

	assign en       = ~vld_q[NST-1] | out_ready;
	assign in_ready = en;

	assign mat = '{in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2, in_r2c3,
	               in_r3c1, in_r3c2, in_r3c3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	mi3_cofactor u_cof (
		.clk    (clk),
		.en     (en),
		.m      (mat),
		.cof_s2 (cof_s2),
		.row_s2 (row_s2)
	);

	mi3_det u_det (
		.clk     (clk),
		.en      (en),
		.row_s2  (row_s2),
		.cof_s2  (cof_s2[0:2]),
		.info_s5 (info_s5)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			cof_s3 <= cof_s2;
			cof_s4 <= cof_s3;
			cof_s5 <= cof_s4;
		end
	end

	// lane i computes inverse entry (r,c) from cofactor (c,r)
	for (genvar i = 0; i < mi3_pkg::NENT; i++) begin : g_lane
		mi3_div_lane u_lane (
			.clk   (clk),
			.en    (en),
			.cof   (cof_s5[(i % 3) * 3 + (i / 3)]),
			.info  (info_s5),
			.res_q (lane_res[i])
		);
	end

	always_comb begin
		any_sat = 1'b0;
		for (int i = 0; i < mi3_pkg::NENT; i++) begin
			any_sat = any_sat | lane_res[i].sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < mi3_pkg::NENT; i++) begin
				out_q[i] <= lane_res[i].res;
			end
			if (lane_res[0].zero)
				stat_q <= mi3_pkg::STAT_SING;
			else if (any_sat)
				stat_q <= mi3_pkg::STAT_SAT;
			else
				stat_q <= mi3_pkg::STAT_OK;
		end
	end

	assign out_valid  = vld_q[NST-1];
	assign out_r1c1   = out_q[0];
	assign out_r1c2   = out_q[1];
	assign out_r1c3   = out_q[2];
	assign out_r2c1   = out_q[3];
	assign out_r2c2   = out_q[4];
	assign out_r2c3   = out_q[5];
	assign out_r3c1   = out_q[6];
	assign out_r3c2   = out_q[7];
	assign out_r3c3   = out_q[8];
	assign inv_status = stat_q;

	`MI3_ASSERT(a_no_rsvd_status, clk, arst_n, out_valid |-> (inv_status == mi3_pkg::STAT_OK || inv_status == mi3_pkg::STAT_SAT || inv_status == mi3_pkg::STAT_SING))
	`MI3_ASSERT(a_sing_zero, clk, arst_n, (out_valid && inv_status == mi3_pkg::STAT_SING) |-> (out_r1c1 == 0 && out_r2c2 == 0 && out_r3c3 == 0 && out_r1c3 == 0))
	`MI3_ASSERT(a_sat_extreme, clk, arst_n, (out_valid && inv_status == mi3_pkg::STAT_SAT) |-> (out_q[0] == mi3_pkg::SAT_POS || out_q[0] == mi3_pkg::SAT_NEG || out_q[1] == mi3_pkg::SAT_POS || out_q[1] == mi3_pkg::SAT_NEG || out_q[2] == mi3_pkg::SAT_POS || out_q[2] == mi3_pkg::SAT_NEG || out_q[3] == mi3_pkg::SAT_POS || out_q[3] == mi3_pkg::SAT_NEG || out_q[4] == mi3_pkg::SAT_POS || out_q[4] == mi3_pkg::SAT_NEG || out_q[5] == mi3_pkg::SAT_POS || out_q[5] == mi3_pkg::SAT_NEG || out_q[6] == mi3_pkg::SAT_POS || out_q[6] == mi3_pkg::SAT_NEG || out_q[7] == mi3_pkg::SAT_POS || out_q[7] == mi3_pkg::SAT_NEG || out_q[8] == mi3_pkg::SAT_POS || out_q[8] == mi3_pkg::SAT_NEG))

endmodule

// ===== rtl/mi3_cofactor.sv =====
// ---------------------------------------------------------------------------
// mi3_cofactor
// Two-stage cofactor unit: 18 products, then nine exact differences.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_cofactor (
	input  logic            clk,
	input  logic            en,
	input  mi3_pkg::entry_t m [mi3_pkg::NENT],
	output mi3_pkg::cof_t   cof_s2 [mi3_pkg::NENT],
	output mi3_pkg::entry_t row_s2 [3]
);

	// cof[k] = m[PA]*m[PB] - m[NA]*m[NB], row-major indices
	localparam logic [3:0] PA [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
	localparam logic [3:0] PB [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
	localparam logic [3:0] NA [9] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
	localparam logic [3:0] NB [9] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

	mi3_pkg::cof_t   pp_s1 [mi3_pkg::NENT];
	mi3_pkg::cof_t   pn_s1 [mi3_pkg::NENT];
	mi3_pkg::entry_t row_s1 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < mi3_pkg::NENT; k++) begin
				pp_s1[k]  <= m[PA[k]] * m[PB[k]];
				pn_s1[k]  <= m[NA[k]] * m[NB[k]];
				cof_s2[k] <= pp_s1[k] - pn_s1[k];
			end
			for (int j = 0; j < 3; j++) begin
				row_s1[j] <= m[j];
				row_s2[j] <= row_s1[j];
			end
		end
	end

endmodule

// ===== rtl/mi3_det.sv =====
// ---------------------------------------------------------------------------
// mi3_det
// Determinant by first-row expansion, split into 32-bit partial products,
// followed by sign and magnitude.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_det (
	input  logic                clk,
	input  logic                en,
	input  mi3_pkg::entry_t     row_s2 [3],
	input  mi3_pkg::cof_t       cof_s2 [3],
	output mi3_pkg::det_info_t  info_s5
);

	logic signed [64:0]            plo_s3 [3];
	logic signed [63:0]            phi_s3 [3];
	logic signed [mi3_pkg::DW-1:0] det_s4;
	logic signed [mi3_pkg::DW-1:0] det_sum;
	logic signed [mi3_pkg::DW-1:0] det_neg;

	// upper partial product is signed, so it has to be sign extended
	always_comb begin
		det_sum = '0;
		for (int j = 0; j < 3; j++) begin
			det_sum = det_sum + mi3_pkg::DW'($signed({phi_s3[j], 32'd0}))
				+ mi3_pkg::DW'(plo_s3[j]);
		end
	end

	assign det_neg = -det_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				plo_s3[j] <= row_s2[j] * $signed({1'b0, cof_s2[j][31:0]});
				phi_s3[j] <= row_s2[j] * $signed(cof_s2[j][63:32]);
			end
			det_s4 <= det_sum;
			info_s5.zero <= (det_s4 == '0);
			info_s5.dneg <= det_s4[mi3_pkg::DW-1];
			info_s5.dmag <= det_s4[mi3_pkg::DW-1] ? det_neg[mi3_pkg::MW-1:0]
			                                      : det_s4[mi3_pkg::MW-1:0];
		end
	end

endmodule

// ===== rtl/mi3_div_lane.sv =====
// ---------------------------------------------------------------------------
// mi3_div_lane
// One divide lane: cofactor * 2^32 / det, restoring, one quotient bit per
// stage, truncated toward zero and saturated to 32 bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mi3_div_lane (
	input  logic               clk,
	input  logic               en,
	input  mi3_pkg::cof_t      cof,
	input  mi3_pkg::det_info_t info,
	output mi3_pkg::lane_res_t res_q
);

	localparam int unsigned QW = mi3_pkg::QW;
	localparam int unsigned MW = mi3_pkg::MW;

	logic [MW:0]   rem_s  [QW+1];
	logic [MW-1:0] dmag_s [QW+1];
	logic [QW-1:0] quo_s  [QW+1];
	logic          neg_s  [QW+1];
	logic          ovf_s  [QW+1];
	logic          zero_s [QW+1];

	logic [mi3_pkg::CW-1:0] cmag;
	logic [MW:0]            shl [1:QW];
	logic                   ge  [1:QW];
	logic                   sat;
	logic                   neg_f;
	logic [QW-1:0]          q_f;

	assign cmag = cof[mi3_pkg::CW-1] ? mi3_pkg::CW'(-cof) : mi3_pkg::CW'(cof);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= (MW+1)'(cmag);
			dmag_s[0] <= info.dmag;
			quo_s[0]  <= '0;
			neg_s[0]  <= cof[mi3_pkg::CW-1] ^ info.dneg;
			// quotient of 2^32 or more when the cofactor reaches the det
			ovf_s[0]  <= (MW'(cmag) >= info.dmag);
			zero_s[0] <= info.zero;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		assign shl[k] = {rem_s[k-1][MW-1:0], 1'b0};
		assign ge[k]  = (shl[k] >= {1'b0, dmag_s[k-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge[k] ? shl[k] - {1'b0, dmag_s[k-1]} : shl[k];
				quo_s[k]  <= {quo_s[k-1][QW-2:0], ge[k]};
				dmag_s[k] <= dmag_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				ovf_s[k]  <= ovf_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end
	end

	assign q_f   = quo_s[QW];
	assign neg_f = neg_s[QW];
	assign sat   = ovf_s[QW] | (neg_f ? (q_f > mi3_pkg::SAT_NEG) : q_f[QW-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.zero <= zero_s[QW];
			res_q.sat  <= sat & ~zero_s[QW];
			if (zero_s[QW])
				res_q.res <= '0;
			else if (sat)
				res_q.res <= neg_f ? mi3_pkg::SAT_NEG : mi3_pkg::SAT_POS;
			else
				res_q.res <= neg_f ? QW'(-q_f) : q_f;
		end
	end

endmodule
